// ===== design/hp2hb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hp2hb_pkg
// Types, constants and the arctangent table of the harmonic polar to
// Hermitian bin unit.
// ----------------------------------------------------------------------------
package hp2hb_pkg;

    // Field widths.
    localparam int IDX_W   = 16;
    localparam int MAG_W   = 16;
    localparam int PH_W    = 16;
    localparam int BIN_W   = 16;
    localparam int DATA_W  = 41;
    localparam int FFT_W   = 17;

    // FFT length limits and reset values.
    localparam logic [FFT_W-1:0] MAX_FFT_SIZE   = 17'd65536;
    localparam logic [FFT_W-1:0] MIN_FFT_SIZE   = 17'd2;
    localparam logic [FFT_W-1:0] FFT_SIZE_RESET = 17'd1024;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_FFT_SIZE = 1'b0;
    localparam logic REG_ODD_MODE = 1'b1;

    // Scaling: amp = floor(magnitude * N * G / 2^24), G about 2^32 * K / sqrt2.
    localparam int PROD_W = MAG_W + FFT_W;              // magnitude * N
    localparam int GHI_W  = 15;
    localparam int GLO_W  = 16;
    localparam logic [GHI_W-1:0] GAIN_HI = 15'd28140;   // G >> 16
    localparam logic [GLO_W-1:0] GAIN_LO = 16'd44438;   // G & 0xFFFF
    localparam int PPHI_W = PROD_W + GHI_W;
    localparam int PPLO_W = PROD_W + GLO_W;
    localparam int SUM_W  = PPLO_W;

    // CORDIC.
    localparam int CORDIC_STAGES = 16;
    localparam int XW = 42;   // x and y datapath, amplitude stays below 2^40
    localparam int ZW = 33;   // residual angle, full turn is 2^32
    localparam int AT_W = 30;
    localparam logic [PH_W-1:0] QUARTER_TURN = 16'h4000;
    localparam logic [PH_W-1:0] EIGHTH_TURN  = 16'h2000;
    localparam logic signed [XW-1:0] ROUND_HALF = 42'sd128;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    // Per-item control that travels alongside the datapath.
    typedef struct packed {
        logic [BIN_W-1:0] bin_a;    // bin of the first result
        logic [BIN_W-1:0] bin_b;    // mirror bin of the second result
        t_quad            quad;     // quarter turns taken out before CORDIC
        logic             conj_a;   // first result carries the conjugate
        logic             two;      // item gives two results
        logic             oor;      // harmonic above N/2
        logic             eos;      // final harmonic of the set
    } t_side;

    function automatic logic [AT_W-1:0] atan_entry(input int idx);
        logic [AT_W-1:0] v;
        unique case (idx)
            0:  v = 30'd536870912;
            1:  v = 30'd316933406;
            2:  v = 30'd167458907;
            3:  v = 30'd85004756;
            4:  v = 30'd42667331;
            5:  v = 30'd21354465;
            6:  v = 30'd10679838;
            7:  v = 30'd5340245;
            8:  v = 30'd2670163;
            9:  v = 30'd1335087;
            10: v = 30'd667544;
            11: v = 30'd333772;
            12: v = 30'd166886;
            13: v = 30'd83443;
            14: v = 30'd41722;
            15: v = 30'd20861;
            16: v = 30'd10430;
            17: v = 30'd5215;
            18: v = 30'd2608;
            19: v = 30'd1304;
            20: v = 30'd652;
            21: v = 30'd326;
            22: v = 30'd163;
            23: v = 30'd81;
            24: v = 30'd41;
            25: v = 30'd20;
            26: v = 30'd10;
            27: v = 30'd5;
            28: v = 30'd3;
            29: v = 30'd1;
            30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // Round half up and drop the 8 extra fraction bits. The datapath bound
    // keeps the result well inside the 41-bit range.
    function automatic logic signed [DATA_W-1:0] round_part(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] s;
        s = v + ROUND_HALF;
        return DATA_W'(s >>> 8);
    endfunction

    function automatic logic signed [DATA_W-1:0] neg_sat(input logic signed [DATA_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v == DATA_MIN) begin
            r = DATA_MAX;
        end else begin
            r = -v;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/harmonic_polar_to_hermitian_bins_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// harmonic_polar_to_hermitian_bins_unit
// Converts one harmonic's RMS magnitude and sine phase into the bin k and
// mirror bin N-k coefficients of an N-point FFT with a pipelined CORDIC.
// ----------------------------------------------------------------------------
// Each input transaction runs through a fixed pipeline of an input register,
// 3 scaling stages (magnitude times N, two partial products against the gain
// constant, their sum), 16 CORDIC rotation stages, a quadrant and rounding
// stage and the output register. A new transaction can enter every cycle
// while the pipeline is not held; the single result port sets the sustained
// rate, as a harmonic that gives one result (bin zero, the Nyquist bin, or an
// out-of-range harmonic) takes one transfer on it and a harmonic that gives a
// bin and its mirror takes two. When the output is stalled, the pipeline
// keeps moving until the stage ahead of the output register is full, and
// then the whole pipeline holds. fft_size (offset 0x0) and odd_mode (offset
// 0x4) are written and read through the APB port and should change only
// while the unit is idle.

module harmonic_polar_to_hermitian_bins_unit
    import hp2hb_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,

    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [PADDR_W-1:0]       paddr,
    input  wire logic [PDATA_W-1:0]       pwdata,
    output      logic [PDATA_W-1:0]       prdata,
    output      logic                     pready,

    input  wire logic                     i_valid,
    output      logic                     o_ready,
    input  wire logic [IDX_W-1:0]         i_harmonic_index,
    input  wire logic [MAG_W-1:0]         i_magnitude,
    input  wire logic [PH_W-1:0]          i_phase,
    input  wire logic                     i_end_of_set,

    output      logic                     o_valid,
    input  wire logic                     i_ready,
    output      logic [BIN_W-1:0]         o_bin_index,
    output      logic signed [DATA_W-1:0] o_real_part,
    output      logic signed [DATA_W-1:0] o_imag_part,
    output      logic                     o_out_of_range,
    output      logic                     o_last,
    output      logic                     o_last_of_set
);

    localparam int CS = CORDIC_STAGES;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [FFT_W-1:0] r_fft_size;
    logic             r_odd_mode;
    logic             w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fft_size <= FFT_SIZE_RESET;
            r_odd_mode <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_FFT_SIZE: r_fft_size <= pwdata[FFT_W-1:0];
                REG_ODD_MODE: r_odd_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FFT_SIZE: prdata = PDATA_W'(r_fft_size);
            REG_ODD_MODE: prdata = PDATA_W'(r_odd_mode);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage ahead of the output register moves together when w_adv is high.
    // ------------------------------------------------------------------
    logic w_adv;
    logic w_take;
    logic w_done;
    logic r_e_vld;
    logic r_e_second;
    logic r_f_vld;
    t_side r_e_sb;

    assign w_done  = r_e_vld && i_ready && (r_e_second || !r_e_sb.two);
    assign w_take  = !r_e_vld || w_done;
    assign w_adv   = !r_f_vld || w_take;
    assign o_ready = w_adv;

    // ------------------------------------------------------------------
    // Input decode: bin numbers, result pattern and angle reduction
    // ------------------------------------------------------------------
    logic [FFT_W-1:0] n_n;
    logic [FFT_W-1:0] n_half;
    logic [FFT_W-1:0] n_k;
    logic [FFT_W-1:0] n_mirror;
    logic [PH_W-1:0]  n_theta;
    logic [PH_W-1:0]  n_rot;
    logic [PH_W-1:0]  n_r16;
    logic             n_nyq;
    logic             n_zero;
    t_side            n_sb;

    always_comb begin
        if (r_fft_size < MIN_FFT_SIZE) begin
            n_n = MIN_FFT_SIZE;
        end else if (r_fft_size > MAX_FFT_SIZE) begin
            n_n = MAX_FFT_SIZE;
        end else begin
            n_n = r_fft_size;
        end
        n_half   = n_n >> 1;
        n_k      = r_odd_mode ? {i_harmonic_index, 1'b1} : {1'b0, i_harmonic_index};
        n_mirror = n_n - n_k;
        n_nyq    = !n_n[0] && (n_k == n_half);
        n_zero   = (n_k == '0);

        // Sine phase to cosine phase, then take out the nearest quarter turn.
        n_theta  = i_phase - QUARTER_TURN;
        n_rot    = n_theta + EIGHTH_TURN;
        n_r16    = n_theta - {n_rot[PH_W-1 -: 2], {(PH_W-2){1'b0}}};

        n_sb.oor    = (n_k > n_half);
        n_sb.bin_a  = n_sb.oor ? '0 : n_k[BIN_W-1:0];
        n_sb.bin_b  = n_mirror[BIN_W-1:0];
        n_sb.quad   = t_quad'(n_rot[PH_W-1 -: 2]);
        n_sb.conj_a = !n_sb.oor && n_nyq;
        n_sb.two    = !n_sb.oor && !n_zero && !n_nyq;
        n_sb.eos    = i_end_of_set;
    end

    // ------------------------------------------------------------------
    // Scaling stages
    // ------------------------------------------------------------------
    logic              r_s1_vld, r_s2_vld, r_s3_vld;
    logic [MAG_W-1:0]  r_s1_mag;
    logic [FFT_W-1:0]  r_s1_n;
    logic [PH_W-1:0]   r_s1_r16, r_s2_r16, r_s3_r16;
    t_side             r_s1_sb, r_s2_sb, r_s3_sb;
    logic [PROD_W-1:0] r_s2_p;
    logic [PPHI_W-1:0] r_s3_hi;
    logic [PPLO_W-1:0] r_s3_lo;
    logic [SUM_W-1:0]  n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= i_valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_mag <= i_magnitude;
            r_s1_n   <= n_n;
            r_s1_r16 <= n_r16;
            r_s1_sb  <= n_sb;

            r_s2_p   <= PROD_W'(r_s1_mag) * PROD_W'(r_s1_n);
            r_s2_r16 <= r_s1_r16;
            r_s2_sb  <= r_s1_sb;

            r_s3_hi  <= PPHI_W'(r_s2_p) * PPHI_W'(GAIN_HI);
            r_s3_lo  <= PPLO_W'(r_s2_p) * PPLO_W'(GAIN_LO);
            r_s3_r16 <= r_s2_r16;
            r_s3_sb  <= r_s2_sb;
        end
    end

    assign n_sum = SUM_W'(r_s3_hi) + SUM_W'(r_s3_lo >> GLO_W);

    // ------------------------------------------------------------------
    // CORDIC rotation stages
    // ------------------------------------------------------------------
    logic signed [XW-1:0] r_cx  [0:CS];
    logic signed [XW-1:0] r_cy  [0:CS];
    logic signed [ZW-1:0] r_cz  [0:CS];
    t_side                r_csb [0:CS];
    logic                 r_cv  [0:CS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (w_adv) begin
            r_cv[0] <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cx[0]  <= XW'(n_sum[SUM_W-1:8]);
            r_cy[0]  <= '0;
            r_cz[0]  <= {r_s3_r16[PH_W-1], r_s3_r16, {(ZW-PH_W-1){1'b0}}};
            r_csb[0] <= r_s3_sb;
        end
    end

    for (genvar i = 0; i < CS; i++) begin : g_cordic
        localparam logic signed [ZW-1:0] ATAN = ZW'(atan_entry(i));
        logic signed [XW-1:0] w_dx;
        logic signed [XW-1:0] w_dy;

        assign w_dx = r_cy[i] >>> i;
        assign w_dy = r_cx[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[i+1] <= 1'b0;
            end else if (w_adv) begin
                r_cv[i+1] <= r_cv[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (!r_cz[i][ZW-1]) begin
                    r_cx[i+1] <= r_cx[i] - w_dx;
                    r_cy[i+1] <= r_cy[i] + w_dy;
                    r_cz[i+1] <= r_cz[i] - ATAN;
                end else begin
                    r_cx[i+1] <= r_cx[i] + w_dx;
                    r_cy[i+1] <= r_cy[i] - w_dy;
                    r_cz[i+1] <= r_cz[i] + ATAN;
                end
                r_csb[i+1] <= r_csb[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Quadrant restore and rounding
    // ------------------------------------------------------------------
    logic signed [XW-1:0]     n_qx, n_qy;
    logic signed [DATA_W-1:0] n_re, n_im;
    logic signed [DATA_W-1:0] r_f_re, r_f_im, r_f_cim;
    t_side                    r_f_sb;

    always_comb begin
        unique case (r_csb[CS].quad)
            QUAD_0: begin n_qx =  r_cx[CS]; n_qy =  r_cy[CS]; end
            QUAD_1: begin n_qx = -r_cy[CS]; n_qy =  r_cx[CS]; end
            QUAD_2: begin n_qx = -r_cx[CS]; n_qy = -r_cy[CS]; end
            QUAD_3: begin n_qx =  r_cy[CS]; n_qy = -r_cx[CS]; end
            default: begin n_qx = r_cx[CS]; n_qy = r_cy[CS]; end
        endcase
        // An out-of-range harmonic reports zero coefficients.
        if (r_csb[CS].oor) begin
            n_re = '0;
            n_im = '0;
        end else begin
            n_re = round_part(n_qx);
            n_im = round_part(n_qy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (w_adv) begin
            r_f_vld <= r_cv[CS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f_re  <= n_re;
            r_f_im  <= n_im;
            r_f_cim <= neg_sat(n_im);
            r_f_sb  <= r_csb[CS];
        end
    end

    // ------------------------------------------------------------------
    // Output register: one or two results per item
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] r_e_re, r_e_im, r_e_cim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld    <= 1'b0;
            r_e_second <= 1'b0;
        end else if (w_take) begin
            r_e_vld    <= r_f_vld;
            r_e_second <= 1'b0;
        end else if (r_e_vld && i_ready) begin
            r_e_second <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_e_re  <= r_f_re;
            r_e_im  <= r_f_im;
            r_e_cim <= r_f_cim;
            r_e_sb  <= r_f_sb;
        end
    end

    assign o_valid        = r_e_vld;
    assign o_bin_index    = r_e_second ? r_e_sb.bin_b : r_e_sb.bin_a;
    assign o_real_part    = r_e_re;
    assign o_imag_part    = (r_e_second || r_e_sb.conj_a) ? r_e_cim : r_e_im;
    assign o_out_of_range = r_e_sb.oor;
    assign o_last         = r_e_second || !r_e_sb.two;
    assign o_last_of_set  = o_last && r_e_sb.eos;

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the harmonic polar to Hermitian bin unit. Harmonic
// transactions go in through a gapped valid/ready driver, and a bit-true
// CORDIC predictor computes the bins expected for each one. A monitor with
// random back-pressure compares every result in order, across a sequence of
// FFT length and odd-mode settings written over the APB port.
// ----------------------------------------------------------------------------
module tb;
    import hp2hb_pkg::*;

    localparam int          HALF_PERIOD  = 4;
    localparam int          RESET_CYCLES = 12;
    localparam int          DRAIN_CYCLES = 30;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          RANDOM_PER_PHASE = 30;
    localparam int          ROT_STEPS = 16;
    localparam longint      GAIN = 64'd1844227478;
    localparam longint      LIM_HI = 64'sd1099511627775;
    localparam longint      LIM_LO = -64'sd1099511627776;
    localparam longint      ARCTAN [ROT_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861
    };

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [MAG_W-1:0] mag;
        logic [PH_W-1:0]  ph;
        logic             eos;
    } t_harm;

    typedef struct {
        logic [BIN_W-1:0]         bin;
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic                     oor;
        logic                     last;
        logic                     los;
    } t_bin;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [PADDR_W-1:0]       paddr = '0;
    logic [PDATA_W-1:0]       pwdata = '0;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic [IDX_W-1:0]         i_harmonic_index = '0;
    logic [MAG_W-1:0]         i_magnitude = '0;
    logic [PH_W-1:0]          i_phase = '0;
    logic                     i_end_of_set = 1'b0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic [BIN_W-1:0]         o_bin_index;
    logic signed [DATA_W-1:0] o_real_part;
    logic signed [DATA_W-1:0] o_imag_part;
    logic                     o_out_of_range;
    logic                     o_last;
    logic                     o_last_of_set;

    t_harm            harmonics_todo[$];
    t_bin             bins_due[$];
    t_harm            cur_harm;
    logic [FFT_W-1:0] fft_reg = FFT_SIZE_RESET;
    logic             odd_reg = 1'b0;
    bit               steady = 1'b0;
    int               n_errors = 0;
    int               send_wait = 0;
    int               recv_wait = 0;
    int               drv_w;
    int               mon_w;
    int               cycles = 0;

    harmonic_polar_to_hermitian_bins_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_harmonic_index (i_harmonic_index),
        .i_magnitude      (i_magnitude),
        .i_phase          (i_phase),
        .i_end_of_set     (i_end_of_set),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_bin_index      (o_bin_index),
        .o_real_part      (o_real_part),
        .o_imag_part      (o_imag_part),
        .o_out_of_range   (o_out_of_range),
        .o_last           (o_last),
        .o_last_of_set    (o_last_of_set)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 10);
    endfunction

    // Register values outside the legal range are clamped by the unit.
    function automatic longint unsigned eff_size(input logic [FFT_W-1:0] v);
        longint unsigned n;
        n = v;
        if (n < 2) n = 2;
        if (n > 65536) n = 65536;
        return n;
    endfunction

    function automatic longint clamp41(input longint v);
        if (v > LIM_HI) return LIM_HI;
        if (v < LIM_LO) return LIM_LO;
        return v;
    endfunction

    function automatic longint round8(input longint v);
        return clamp41((v + 128) >>> 8);
    endfunction

    // Expected bins of one harmonic, appended to bins_due in output order.
    task automatic compute_bins(input t_harm h);
        longint unsigned n, half, k, p, glo, ghi, u;
        logic [PH_W-1:0] ph_shift;
        logic [31:0]     theta, q, rr;
        longint          x, y, z, dx, dy, t, re, im, cim;
        t_bin            b;
        n = eff_size(fft_reg);
        half = n >> 1;
        k = h.idx;
        if (odd_reg) k = 2 * k + 1;
        if (k > half) begin
            b = '{bin: '0, re: '0, im: '0, oor: 1'b1, last: 1'b1, los: h.eos};
            bins_due.push_back(b);
            return;
        end
        p = longint'(h.mag) * n;
        glo = p * (GAIN & 64'hFFFF);
        ghi = p * (GAIN >> 16);
        u = ghi + (glo >> 16);
        x = longint'(u >> 8);
        y = 0;
        // Phase is given as a sine angle; a quarter turn back makes it cosine.
        ph_shift = h.ph - QUARTER_TURN;
        theta = {ph_shift, 16'h0000};
        q = ((theta + 32'h2000_0000) >> 30) & 32'd3;
        rr = theta - (q << 30);
        z = longint'(signed'(rr));
        for (int i = 0; i < ROT_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN[i];
            end
        end
        case (t_quad'(q[1:0]))
            QUAD_1: begin
                t = x;
                x = -y;
                y = t;
            end
            QUAD_2: begin
                x = -x;
                y = -y;
            end
            QUAD_3: begin
                t = x;
                x = y;
                y = -t;
            end
            default: ;
        endcase
        re = round8(x);
        im = round8(y);
        cim = clamp41(-im);
        if (k == 0) begin
            b = '{bin: '0, re: re[DATA_W-1:0], im: im[DATA_W-1:0],
                  oor: 1'b0, last: 1'b1, los: h.eos};
            bins_due.push_back(b);
        end else if ((n & 1) == 0 && k == half) begin
            b = '{bin: k[BIN_W-1:0], re: re[DATA_W-1:0],
                  im: cim[DATA_W-1:0], oor: 1'b0, last: 1'b1, los: h.eos};
            bins_due.push_back(b);
        end else begin
            b = '{bin: k[BIN_W-1:0], re: re[DATA_W-1:0], im: im[DATA_W-1:0],
                  oor: 1'b0, last: 1'b0, los: 1'b0};
            bins_due.push_back(b);
            t = n - k;
            b = '{bin: t[BIN_W-1:0], re: re[DATA_W-1:0],
                  im: cim[DATA_W-1:0], oor: 1'b0, last: 1'b1, los: h.eos};
            bins_due.push_back(b);
        end
    endtask

    task automatic check_bin();
        t_bin b;
        if (bins_due.size() == 0) begin
            $error("unexpected result at bin %0d", o_bin_index);
            n_errors++;
        end else begin
            b = bins_due.pop_front();
            if (o_bin_index !== b.bin) begin
                $error("bin_index: expected %0d, got %0d", b.bin, o_bin_index);
                n_errors++;
            end
            if (o_real_part !== b.re) begin
                $error("real_part: expected %0d, got %0d", b.re, o_real_part);
                n_errors++;
            end
            if (o_imag_part !== b.im) begin
                $error("imag_part: expected %0d, got %0d", b.im, o_imag_part);
                n_errors++;
            end
            if (o_out_of_range !== b.oor) begin
                $error("out_of_range: expected %0d, got %0d", b.oor, o_out_of_range);
                n_errors++;
            end
            if (o_last !== b.last) begin
                $error("last: expected %0d, got %0d", b.last, o_last);
                n_errors++;
            end
            if (o_last_of_set !== b.los) begin
                $error("last_of_set: expected %0d, got %0d", b.los, o_last_of_set);
                n_errors++;
            end
        end
    endtask

    // Harmonic driver: holds each transaction until accepted, then, outside steady
    // phases, waits a random number of cycles before presenting the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_wait <= 0;
        end else if (!(i_valid && !o_ready)) begin
            if (i_valid) begin
                compute_bins(cur_harm);
                drv_w = draw_gap();
            end else begin
                drv_w = send_wait;
            end
            if (drv_w == 0 && harmonics_todo.size() > 0) begin
                cur_harm = harmonics_todo.pop_front();
                i_valid <= 1'b1;
                i_harmonic_index <= cur_harm.idx;
                i_magnitude <= cur_harm.mag;
                i_phase <= cur_harm.ph;
                i_end_of_set <= cur_harm.eos;
                send_wait <= 0;
            end else begin
                i_valid <= 1'b0;
                send_wait <= (drv_w > 0) ? drv_w - 1 : 0;
            end
        end
    end

    // Result monitor with random back-pressure after each transaction, outside steady phases.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            recv_wait <= 0;
        end else begin
            if (o_valid && i_ready) begin
                check_bin();
                mon_w = draw_gap();
            end else if (recv_wait > 0) begin
                mon_w = recv_wait - 1;
            end else begin
                mon_w = 0;
            end
            recv_wait <= mon_w;
            i_ready <= (mon_w == 0);
        end
    end

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(input logic [FFT_W-1:0] size, input logic odd);
        apb_write(PADDR_W'({REG_FFT_SIZE, 2'b00}), PDATA_W'(size));
        apb_write(PADDR_W'({REG_ODD_MODE, 2'b00}), PDATA_W'(odd));
        fft_reg = size;
        odd_reg = odd;
        @(negedge i_clk);
    endtask

    task automatic add_harm(input int idx, input int mag, input int ph, input bit eos);
        t_harm h;
        h = '{idx: idx[IDX_W-1:0], mag: mag[MAG_W-1:0], ph: ph[PH_W-1:0], eos: eos};
        harmonics_todo.push_back(h);
    endtask

    // Mostly in-range harmonics, with the edges of the range and some
    // out-of-range and fully random indexes mixed in.
    task automatic queue_random_harmonics(input int count);
        longint unsigned half, top;
        int idx, mag, sel;
        half = eff_size(fft_reg) >> 1;
        top = odd_reg ? (half - 1) / 2 : half;
        for (int j = 0; j < count; j++) begin
            sel = $urandom_range(0, 15);
            case (sel)
                0: idx = 0;
                1: idx = int'(top);
                2: idx = int'(top) + 1;
                3: idx = $urandom_range(0, 65535);
                default: idx = $urandom_range(0, int'(top));
            endcase
            sel = $urandom_range(0, 7);
            mag = (sel == 0) ? 65535 : (sel == 1) ? 0 : $urandom_range(0, 65535);
            add_harm(idx, mag, $urandom_range(0, 65535), $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (harmonics_todo.size() != 0 || i_valid || bins_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [FFT_W-1:0] sizes [13];
        logic             odds  [13];
        sizes = '{17'd65536, 17'd65536, 17'd2, 17'd2, 17'd0, 17'd1, 17'h1FFFF,
                  17'd65537, 17'd7, 17'd6, 17'd3, 17'd0, 17'd1024};
        odds  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1,
                  1'b0, 1'b0, 1'b0};
        sizes[11] = FFT_W'($urandom_range(2, 65536));
        odds[11] = 1'($urandom_range(0, 1));
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: N = 1024, natural harmonic numbering.
        add_harm(0, 16'hFFFF, 16'h0000, 1'b0);
        add_harm(1, 16'hFFFF, 16'h0000, 1'b0);
        add_harm(1, 16'hFFFF, 16'h2000, 1'b0);
        add_harm(1, 16'hFFFF, 16'h4000, 1'b0);
        add_harm(1, 16'hFFFF, 16'h6000, 1'b0);
        add_harm(1, 16'hFFFF, 16'h8000, 1'b0);
        add_harm(1, 16'hFFFF, 16'hA000, 1'b0);
        add_harm(1, 16'hFFFF, 16'hC000, 1'b0);
        add_harm(1, 16'hFFFF, 16'hE000, 1'b0);
        add_harm(1, 16'hFFFF, 16'h1FFF, 1'b0);
        add_harm(1, 16'hFFFF, 16'hFFFF, 1'b0);
        add_harm(511, 16'h0001, 16'h1234, 1'b0);
        add_harm(512, 16'h8000, 16'h4000, 1'b0);
        add_harm(513, 16'hFFFF, 16'h0000, 1'b0);
        add_harm(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        add_harm(2, 16'h0000, 16'h0000, 1'b1);
        add_harm(3, 16'hAAAA, 16'h5555, 1'b1);
        add_harm(5, 16'h5555, 16'hAAAA, 1'b0);
        queue_random_harmonics(RANDOM_PER_PHASE);

        for (int ph = 0; ph < 13; ph++) begin
            wait_idle();
            steady = (ph % 4 == 1);
            set_config(sizes[ph], odds[ph]);
            queue_random_harmonics(RANDOM_PER_PHASE);
        end
        wait_idle();

        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== harmonic_polar_to_hermitian_bins_unit.f =====
design/hp2hb_pkg.sv
design/harmonic_polar_to_hermitian_bins_unit.sv
tb/sv/tb.sv
